// ===== rtl/avsync_pkg.sv =====
// Shared types and constants for the A/V sync frame scheduler.
// Used by av_sync_frame_delay_top; depends on nothing else.
package avsync_pkg;

  // Field widths, all times in microseconds
  localparam int unsigned PTS_W     = 48;
  localparam int unsigned NOW_W     = 47;
  localparam int unsigned TIMER_W   = 47;  // frame timer never exceeds 2^47-1
  localparam int unsigned DELAY_W   = 47;
  localparam int unsigned STEP_W    = 24;  // stored timestamp step
  localparam int unsigned CSTEP_W   = 25;  // corrected step, may be doubled
  localparam int unsigned MINSYNC_W = 20;
  localparam int unsigned NOSYNC_W  = 27;
  localparam int unsigned MAXSTEP_W = 24;
  localparam int unsigned MINDLY_W  = 20;
  localparam int unsigned CFG_W     = 27;
  localparam int unsigned CFG_IDX_W = 2;

  // Stream payload widths, padded to whole bytes
  localparam int unsigned S_TDATA_W = 144;
  localparam int unsigned M_TDATA_W = 72;

  // Register reset values
  localparam logic [MINSYNC_W-1:0] MINSYNC_RST = MINSYNC_W'(10000);
  localparam logic [NOSYNC_W-1:0]  NOSYNC_RST  = NOSYNC_W'(1000000);
  localparam logic [MAXSTEP_W-1:0] MAXSTEP_RST = MAXSTEP_W'(1000000);
  localparam logic [MINDLY_W-1:0]  MINDLY_RST  = MINDLY_W'(10000);

  typedef enum logic {
    CMD_SCHEDULE = 1'b0,
    CMD_RESTART  = 1'b1
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_SYNC = 2'd0,
    REG_NOSYNC   = 2'd1,
    REG_MAX_STEP = 2'd2,
    REG_MIN_DLY  = 2'd3
  } cfg_idx_e;

endpackage

// ===== rtl/av_sync_frame_delay_top.sv =====
// A/V sync frame scheduler: input register, one pass of step correction and
// frame timer update, result register. Depends on avsync_pkg.
//
// Each transfer on the slave stream is one command. A schedule command
// (tuser 0) yields one result transfer with the wait before the frame is shown,
// a late flag and the corrected timestamp step; a restart command (tuser 1)
// reloads the frame timer with now and yields nothing. One item is taken per
// clock while no held result stalls a schedule item in the input register.
// The step correction, timer add and delay clamp form a single short chain of
// adders and compares between the input and result registers, and the state
// it updates is ready for the next item in the following cycle.
// Configuration registers are written through cfg_we_i/cfg_idx_i/cfg_data_i
// and should only change while no item is in flight.
module av_sync_frame_delay_top
  import avsync_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,

  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,

  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // frame_pts_us[47:0], audio_clock_us[95:48], now_us[142:96], zero pad [143]
  input  logic [S_TDATA_W-1:0] s_axis_tdata,
  // command[0]
  input  logic                 s_axis_tuser,

  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // delay_us[46:0], frame_step_us[71:47]
  output logic [M_TDATA_W-1:0] m_axis_tdata,
  // late[0]
  output logic                 m_axis_tuser
);

  // Configuration registers
  logic [MINSYNC_W-1:0] min_sync_q;
  logic [NOSYNC_W-1:0]  nosync_q;
  logic [MAXSTEP_W-1:0] max_step_q;
  logic [MINDLY_W-1:0]  min_dly_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_sync_q <= MINSYNC_RST;
      nosync_q   <= NOSYNC_RST;
      max_step_q <= MAXSTEP_RST;
      min_dly_q  <= MINDLY_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        REG_MIN_SYNC: min_sync_q <= cfg_data_i[MINSYNC_W-1:0];
        REG_NOSYNC:   nosync_q   <= cfg_data_i[NOSYNC_W-1:0];
        REG_MAX_STEP: max_step_q <= cfg_data_i[MAXSTEP_W-1:0];
        REG_MIN_DLY:  min_dly_q  <= cfg_data_i[MINDLY_W-1:0];
        default:      ;
      endcase
    end
  end

  // Input register
  logic              in_valid_q;
  cmd_e              in_cmd_q;
  logic [PTS_W-1:0]  in_pts_q;
  logic [PTS_W-1:0]  in_audio_q;
  logic [NOW_W-1:0]  in_now_q;

  // Result register
  logic               out_valid_q;
  logic               out_late_q;
  logic [DELAY_W-1:0] out_delay_q;
  logic [CSTEP_W-1:0] out_step_q;

  // Scheduler state
  logic [PTS_W-1:0]   last_pts_q,  last_pts_d;
  logic [STEP_W-1:0]  good_step_q, good_step_d;
  logic [TIMER_W-1:0] timer_q,     timer_d;

  logic s_xfer;
  logic advance;
  logic is_restart;

  assign is_restart    = (in_cmd_q == CMD_RESTART);
  // A restart needs no result slot; a schedule needs the result register free.
  assign advance       = in_valid_q && (is_restart || !out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign s_xfer        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_xfer) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_xfer) begin
      in_cmd_q   <= cmd_e'(s_axis_tuser);
      in_pts_q   <= s_axis_tdata[PTS_W-1:0];
      in_audio_q <= s_axis_tdata[2*PTS_W-1:PTS_W];
      in_now_q   <= s_axis_tdata[2*PTS_W+NOW_W-1:2*PTS_W];
    end
  end

  // Step derivation and correction
  logic signed [PTS_W:0]  diff;
  logic signed [PTS_W:0]  offset;
  logic signed [PTS_W:0]  thr_s;
  logic signed [PTS_W:0]  nosync_s;
  logic [STEP_W-1:0]      step_raw;
  logic [STEP_W-1:0]      thr;
  logic                   diff_bad;
  logic                   in_window;
  logic [CSTEP_W-1:0]     step_corr;
  logic [TIMER_W:0]       timer_sum;
  logic [TIMER_W-1:0]     timer_new;
  logic signed [TIMER_W:0] slack;
  logic [DELAY_W-1:0]     delay;
  logic                   late;

  always_comb begin
    diff     = $signed({in_pts_q[PTS_W-1], in_pts_q})
             - $signed({last_pts_q[PTS_W-1], last_pts_q});
    diff_bad = (diff <= 0) || (diff >= $signed({(PTS_W+1-MAXSTEP_W)'(0), max_step_q}));
    step_raw = diff_bad ? good_step_q : diff[STEP_W-1:0];

    offset   = $signed({in_pts_q[PTS_W-1], in_pts_q})
             - $signed({in_audio_q[PTS_W-1], in_audio_q});
    thr      = (step_raw > STEP_W'(min_sync_q)) ? step_raw : STEP_W'(min_sync_q);
    thr_s    = $signed({(PTS_W+1-STEP_W)'(0), thr});
    nosync_s = $signed({(PTS_W+1-NOSYNC_W)'(0), nosync_q});
    // |offset| < nosync, written as a two-sided window
    in_window = (offset < nosync_s) && (offset > -nosync_s);

    step_corr = {1'b0, step_raw};
    if (in_window) begin
      if (offset <= -thr_s) begin
        step_corr = '0;
      end else if (offset > thr_s) begin
        step_corr = {step_raw, 1'b0};
      end
    end

    // The timer is at most 2^47-1, so a set top bit of the sum means overflow.
    timer_sum = {1'b0, timer_q} + (TIMER_W+1)'(step_corr);
    timer_new = timer_sum[TIMER_W] ? '1 : timer_sum[TIMER_W-1:0];

    slack = $signed({1'b0, timer_new}) - $signed({1'b0, in_now_q});
    late  = slack[TIMER_W];
    if (late) begin
      delay = '0;
    end else if (slack[DELAY_W-1:0] < DELAY_W'(min_dly_q)) begin
      delay = DELAY_W'(min_dly_q);
    end else begin
      delay = slack[DELAY_W-1:0];
    end

    last_pts_d  = last_pts_q;
    good_step_d = good_step_q;
    timer_d     = timer_q;
    if (advance) begin
      if (is_restart) begin
        timer_d = in_now_q;
      end else begin
        last_pts_d  = in_pts_q;
        good_step_d = step_raw;
        timer_d     = timer_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_pts_q  <= '0;
      good_step_q <= '0;
      timer_q     <= '0;
    end else begin
      last_pts_q  <= last_pts_d;
      good_step_q <= good_step_d;
      timer_q     <= timer_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && !is_restart) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && !is_restart) begin
      out_late_q  <= late;
      out_delay_q <= delay;
      out_step_q  <= step_corr;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_step_q, out_delay_q};
  assign m_axis_tuser  = out_late_q;

  // A late result always carries a zero delay.
  a_late_zero_delay : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_late_q |-> out_delay_q == '0)
    else $error("late result with nonzero delay");

  // A new result only appears after a schedule command left the input register.
  a_result_source : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(advance && !is_restart))
    else $error("result without a schedule command");

  // A held input item is neither lost nor altered.
  a_input_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !advance |=> in_valid_q && $stable(in_pts_q) && $stable(in_now_q))
    else $error("stalled input item changed");

  // Scheduling a frame never moves the frame timer backward.
  a_timer_monotone : assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && !is_restart |=> timer_q >= $past(timer_q))
    else $error("frame timer moved backward on schedule");

endmodule

// ===== verif/av_sync_frame_delay_top_test.sv =====
// Self-checking testbench for av_sync_frame_delay_top: directed, register-extreme,
// backpressure and random frame traffic, checked against an in-bench predictor.
// Depends on avsync_pkg and av_sync_frame_delay_top only.
module av_sync_frame_delay_top_test
  import avsync_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam longint TIME_MAX   = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint PTS_MAX    = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint PTS_MIN    = -PTS_MAX - 1;
  localparam int     SETTLE_CYC = 8;
  localparam int     DRAIN_CYC  = 20000;
  localparam int     HOLD_CYC   = 300;

  typedef struct {
    logic               late;
    logic [DELAY_W-1:0] delay_us;
    logic [CSTEP_W-1:0] frame_step_us;
  } sched_result_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]     cfg_data_i;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  // frame_pts_us[47:0], audio_clock_us[95:48], now_us[142:96], zero pad [143]
  logic [S_TDATA_W-1:0] s_axis_tdata;
  // command[0]
  logic                 s_axis_tuser;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  // delay_us[46:0], frame_step_us[71:47]
  logic [M_TDATA_W-1:0] m_axis_tdata;
  // late[0]
  logic                 m_axis_tuser;

  // Predictor state and its copy of the configuration
  longint pred_last_pts;
  longint pred_last_step;
  longint pred_timer;
  longint reg_min_sync;
  longint reg_nosync;
  longint reg_max_step;
  longint reg_min_dly;

  sched_result_t sched_q[$];
  int fail_cnt    = 0;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int hold_req    = 0;

  av_sync_frame_delay_top u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Works out the result of one accepted command and advances the predicted state.
  task automatic predict_schedule(input cmd_e cmd, input logic [PTS_W-1:0] pts_raw,
                                  input logic [PTS_W-1:0] audio_raw,
                                  input logic [NOW_W-1:0] now_raw,
                                  output bit has_res, output sched_result_t res);
    longint pts_v, audio_v, now_v, diff, step, offset, mag, thr, slack;
    pts_v   = $signed(pts_raw);
    audio_v = $signed(audio_raw);
    now_v   = now_raw;
    has_res = 1'b0;
    res     = '{late: 1'b0, delay_us: '0, frame_step_us: '0};
    if (cmd == CMD_RESTART) begin
      pred_timer = (now_v > TIME_MAX) ? TIME_MAX : now_v;
    end else begin
      diff = pts_v - pred_last_pts;
      if (diff <= 0 || diff >= reg_max_step) begin
        step = pred_last_step;
      end else begin
        step = diff;
      end
      pred_last_step = step & 64'hFF_FFFF;
      pred_last_pts  = pts_v;

      offset = pts_v - audio_v;
      mag    = (offset < 0) ? -offset : offset;
      thr    = (step > reg_min_sync) ? step : reg_min_sync;
      if (mag < reg_nosync) begin
        if (offset <= -thr) begin
          step = 0;
        end else if (offset > thr) begin
          step = step * 2;
        end
      end

      if (step > TIME_MAX - pred_timer) begin
        pred_timer = TIME_MAX;
      end else begin
        pred_timer = pred_timer + step;
      end

      slack   = pred_timer - now_v;
      has_res = 1'b1;
      if (slack < 0) begin
        res.late     = 1'b1;
        res.delay_us = '0;
      end else begin
        if (slack < reg_min_dly) slack = reg_min_dly;
        if (slack > TIME_MAX) slack = TIME_MAX;
        res.delay_us = slack[DELAY_W-1:0];
      end
      res.frame_step_us = step[CSTEP_W-1:0];
    end
  endtask

  // Offers one command on the slave stream and returns at the edge it transfers.
  task automatic send_frame(input cmd_e cmd, input longint pts, input longint audio,
                            input longint now);
    sched_result_t res;
    bit            has_res;
    if (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {1'b0, now[NOW_W-1:0], audio[PTS_W-1:0], pts[PTS_W-1:0]};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_schedule(cmd, pts[PTS_W-1:0], audio[PTS_W-1:0], now[NOW_W-1:0], has_res, res);
    if (has_res) sched_q.push_back(res);
  endtask

  // Stops offering, waits for every outstanding result, then lets the pipeline settle.
  task automatic wait_results_drained();
    int waited;
    waited = 0;
    s_axis_tvalid <= 1'b0;
    while (sched_q.size() != 0 && waited < DRAIN_CYC) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  task automatic put_reg(input cfg_idx_e idx, input logic [CFG_W-1:0] value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
  endtask

  task automatic program_regs(input logic [CFG_W-1:0] min_sync, input logic [CFG_W-1:0] nosync,
                              input logic [CFG_W-1:0] max_step, input logic [CFG_W-1:0] min_dly);
    wait_results_drained();
    put_reg(REG_MIN_SYNC, min_sync);
    put_reg(REG_NOSYNC, nosync);
    put_reg(REG_MAX_STEP, max_step);
    put_reg(REG_MIN_DLY, min_dly);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    reg_min_sync = min_sync[MINSYNC_W-1:0];
    reg_nosync   = nosync[NOSYNC_W-1:0];
    reg_max_step = max_step[MAXSTEP_W-1:0];
    reg_min_dly  = min_dly[MINDLY_W-1:0];
  endtask

  function automatic longint rand48();
    logic [PTS_W-1:0] v;
    v = PTS_W'({$urandom, $urandom});
    return $signed(v);
  endfunction

  // A wall time around the predicted frame timer, so both late and early frames occur.
  function automatic longint near_timer();
    longint t;
    t = pred_timer + longint'($urandom_range(600000)) - 300000;
    if (t < 0) t = 0;
    if (t > TIME_MAX) t = TIME_MAX;
    return t;
  endfunction

  // Mostly well-formed frame sequences that follow the predicted timestamp, with
  // offsets aimed at the correction thresholds; the rest is restarts and noise.
  task automatic send_random_frames(input int count);
    longint pts, audio, now, step, thr, offset, span;
    int     pick;
    cmd_e   cmd;
    for (int k = 0; k < count; k++) begin
      pick = $urandom_range(99);
      cmd  = CMD_SCHEDULE;
      if (pick < 6) begin
        cmd   = CMD_RESTART;
        pts   = rand48();
        audio = rand48();
        now   = $urandom_range(1) ? (rand48() & TIME_MAX) : near_timer();
      end else if (pick < 18) begin
        cmd   = cmd_e'($urandom_range(1));
        pts   = rand48();
        audio = rand48();
        now   = rand48() & TIME_MAX;
      end else begin
        span = (reg_max_step > 1) ? reg_max_step - 1 : 1;
        if (span > 200000) span = 200000;
        pick = $urandom_range(99);
        if (pick < 70) begin
          step = longint'($urandom_range(1, int'(span)));
        end else if (pick < 80) begin
          step = -longint'($urandom_range(100000));
        end else if (pick < 90) begin
          step = reg_max_step + longint'($urandom_range(1000));
        end else begin
          step = longint'($urandom_range(30000000));
        end
        pts = pred_last_pts + step;
        thr = (step > 0 && step < reg_max_step) ? step : pred_last_step;
        if (thr < reg_min_sync) thr = reg_min_sync;
        pick = $urandom_range(99);
        if (pick < 25) begin
          offset = -thr - longint'($urandom_range(int'(thr)));
        end else if (pick < 50) begin
          offset = thr + longint'($urandom_range(int'(thr)));
        end else if (pick < 60) begin
          offset = -thr;
        end else if (pick < 70) begin
          offset = thr;
        end else if (pick < 80) begin
          offset = ($urandom_range(1) ? thr : -thr) + ($urandom_range(1) ? 1 : -1);
        end else if (pick < 90) begin
          offset = longint'($urandom_range(int'(2 * thr))) - thr;
        end else begin
          offset = reg_nosync + longint'($urandom_range(1000));
          if ($urandom_range(1)) offset = -offset;
        end
        audio = pts - offset;
        now   = near_timer();
      end
      send_frame(cmd, pts, audio, now);
    end
  endtask

  task automatic test_directed_cases();
    tx_idle_pct = 16;
    rx_idle_pct = 65;
    send_frame(CMD_RESTART, 0, 0, 1000);
    send_frame(CMD_SCHEDULE, 0, 0, 0);                   // zero step
    send_frame(CMD_SCHEDULE, 40000, 40000, 1000);        // plain step, in sync
    send_frame(CMD_SCHEDULE, 80000, 200000, 2000);       // video lags, step dropped
    send_frame(CMD_SCHEDULE, 120000, 0, 3000);           // video leads, step doubled
    send_frame(CMD_SCHEDULE, 160000, 200000, 4000);      // lag exactly at threshold
    send_frame(CMD_SCHEDULE, 200000, 160000, 5000);      // lead exactly at threshold
    send_frame(CMD_SCHEDULE, 240000, -760000, 6000);     // offset at the no-sync limit
    send_frame(CMD_SCHEDULE, 245000, 230000, 7000);      // threshold set by the minimum
    send_frame(CMD_SCHEDULE, 100000, 100000, 8000);      // timestamp goes backward
    send_frame(CMD_SCHEDULE, 1100000, 1100000, 9000);    // step equal to the maximum
    send_frame(CMD_SCHEDULE, 1130000, 1130000, TIME_MAX); // late frame
    send_frame(CMD_RESTART, 0, 0, TIME_MAX);
    send_frame(CMD_SCHEDULE, 1160000, 1160000, 0);       // timer saturates, huge delay
    send_frame(CMD_SCHEDULE, PTS_MAX, PTS_MIN, TIME_MAX);
    send_frame(CMD_SCHEDULE, PTS_MIN, PTS_MAX, 0);
    send_frame(CMD_RESTART, PTS_MAX, PTS_MIN, 0);
    send_frame(CMD_SCHEDULE, PTS_MIN + 30000, PTS_MIN + 30000, 25000); // short delay
    send_frame(CMD_SCHEDULE, -1, -1, 1);
    wait_results_drained();
  endtask

  task automatic test_register_extremes();
    program_regs('0, '0, '0, '0);
    send_random_frames(25);
    program_regs('1, '1, '1, '1);
    send_random_frames(25);
    program_regs(CFG_W'(1000000), CFG_W'(100000000), CFG_W'(10000000), CFG_W'(1000000));
    send_random_frames(25);
    program_regs(CFG_W'(0), CFG_W'(1), CFG_W'(1), CFG_W'(0));
    send_random_frames(25);
    program_regs(CFG_W'(MINSYNC_RST), CFG_W'(NOSYNC_RST), CFG_W'(MAXSTEP_RST),
                 CFG_W'(MINDLY_RST));
  endtask

  // The receiver holds off long enough for the block to fill and stall its input.
  task automatic test_output_backpressure();
    tx_idle_pct = 0;
    hold_req++;
    send_random_frames(40);
    wait_results_drained();
  endtask

  task automatic test_random_traffic();
    tx_idle_pct = 16;
    rx_idle_pct = 65;
    send_random_frames(170);
    program_regs(CFG_W'($urandom_range(100000)), CFG_W'($urandom_range(1, 5000000)),
                 CFG_W'($urandom_range(1, 2000000)), CFG_W'($urandom_range(100000)));
    tx_idle_pct = 65;
    rx_idle_pct = 16;
    send_random_frames(170);
    program_regs(CFG_W'($urandom_range(100000)), CFG_W'($urandom_range(1, 5000000)),
                 CFG_W'($urandom_range(1, 2000000)), CFG_W'($urandom_range(100000)));
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    send_random_frames(170);
    wait_results_drained();
  endtask

  // Receiver: random stalls, plus a long hold-off counted here when one is requested.
  always @(posedge clk_i) begin
    int hold_seen;
    int hold_left;
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYC;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    sched_result_t want;
    if (rst_ni === 1'b1 && m_axis_tvalid && m_axis_tready) begin
      if (sched_q.size() == 0) begin
        $display("%0t: result transfer with nothing expected: late %0b delay %0d step %0d",
                 $time, m_axis_tuser, m_axis_tdata[DELAY_W-1:0],
                 m_axis_tdata[DELAY_W +: CSTEP_W]);
        fail_cnt++;
      end else begin
        want = sched_q.pop_front();
        if (m_axis_tuser !== want.late) begin
          $display("%0t: late expected %0b got %0b", $time, want.late, m_axis_tuser);
          fail_cnt++;
        end
        if (m_axis_tdata[DELAY_W-1:0] !== want.delay_us) begin
          $display("%0t: delay_us expected %0d got %0d", $time, want.delay_us,
                   m_axis_tdata[DELAY_W-1:0]);
          fail_cnt++;
        end
        if (m_axis_tdata[DELAY_W +: CSTEP_W] !== want.frame_step_us) begin
          $display("%0t: frame_step_us expected %0d got %0d", $time, want.frame_step_us,
                   m_axis_tdata[DELAY_W +: CSTEP_W]);
          fail_cnt++;
        end
      end
    end
  end

  initial begin
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= REG_MIN_SYNC;
    cfg_data_i    <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= CMD_SCHEDULE;
    m_axis_tready <= 1'b0;
    pred_last_pts  = 0;
    pred_last_step = 0;
    pred_timer     = 0;
    reg_min_sync   = MINSYNC_RST;
    reg_nosync     = NOSYNC_RST;
    reg_max_step   = MAXSTEP_RST;
    reg_min_dly    = MINDLY_RST;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_cases();
    test_register_extremes();
    test_output_backpressure();
    test_random_traffic();

    if (sched_q.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, sched_q.size());
      fail_cnt++;
    end
    if (fail_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("%0t: run did not complete in time", $time);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
